// ===== design/bilx_pkg.sv =====
package bilx_pkg;

    localparam int DATA_AW = 16;
    localparam int DATA_DEPTH = 1 << DATA_AW;
    localparam int BLK_AW = 12;
    localparam int BLOCK_DEPTH = 1 << BLK_AW;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_BLKHDR,
        PH_PAYLOAD,
        PH_FLAGLEN,
        PH_FLAGOFF,
        PH_COPY,
        PH_CLEAR,
        PH_FLAGRD
    } phase_t;

    typedef struct packed {
        logic           we;
        logic [DATA_AW-1:0] waddr;
        logic [7:0]     wdata;
        logic [DATA_AW-1:0] raddr;
    } store_req_t;

endpackage

// ===== design/bilx_ram.sv =====
module bilx_ram #(
    parameter int AW = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);
    logic [7:0] mem [0:(1<<AW)-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== design/block_image_loader_xor_check.sv =====
// Block image loader with XOR check.
// Input channel: in_valid / in_stall carry one container byte per beat.
// Output channel: out_valid / out_stall carry one result beat: a verdict
// per block (kind 0) or a flag word per flag offset (kind 1).
// Header and payload bytes are taken one per cycle while in_stall is low.
// After the last payload byte of a block whose checksum matches, the
// payload is copied from the payload buffer into the data store, one byte
// per cycle, and no byte is taken during the copy; the verdict appears
// when the copy ends. A flag offset reads the data store twice, one byte
// per cycle, and its word is registered after the second read. The first
// header byte of a container starts a clearing pass over all 65536 bytes of
// the data store, during which no byte is taken. Reset returns to the
// header phase; the data store is cleared by the pass at the first header
// byte. A stalled result holds in the output register; no byte is taken
// while a result waits.
module block_image_loader_xor_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic        block_ok,
    output logic [15:0] word_value,
    output logic        out_of_range,
    output logic        is_last
);
    import bilx_pkg::*;

    phase_t phase_reg, phase_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [15:0] blocks_reg, blocks_next;
    logic [31:0] boff_reg, boff_next;
    logic [15:0] bsum_reg, bsum_next;
    logic [15:0] blen_reg, blen_next;
    logic [15:0] xor_reg, xor_next;
    logic [7:0]  held_reg, held_next;
    logic [15:0] flags_reg, flags_next;
    logic [31:0] foff_reg, foff_next;
    logic [DATA_AW:0] clr_reg, clr_next;
    logic [16:0] cp_reg, cp_next;
    logic [1:0]  rd_reg, rd_next;
    logic [7:0]  hi_reg, hi_next;
    logic        okr_reg, okr_next;
    logic        kind_reg, kind_next, last_reg, last_next;
    logic [15:0] word_reg, word_next;
    logic        oor_reg, oor_next;

    logic        pb_we;
    logic [BLK_AW-1:0] pb_waddr, pb_raddr;
    logic [7:0]  pb_rdata;
    store_req_t  sreq;
    logic [7:0]  ds_rdata;

    bilx_ram #(.AW(BLK_AW)) u_pbuf (
        .clk(clk), .we(pb_we), .waddr(pb_waddr), .wdata(in_byte),
        .raddr(pb_raddr), .rdata(pb_rdata)
    );

    bilx_ram #(.AW(DATA_AW)) u_store (
        .clk(clk), .we(sreq.we), .waddr(sreq.waddr), .wdata(sreq.wdata),
        .raddr(sreq.raddr), .rdata(ds_rdata)
    );

    logic take, busy;
    assign busy = (phase_reg == PH_COPY) || (phase_reg == PH_CLEAR)
                  || (phase_reg == PH_FLAGRD);
    assign in_stall = busy || out_valid;
    assign take = in_valid && !in_stall;
    assign kind = kind_reg;
    assign block_ok = okr_reg;
    assign word_value = word_reg;
    assign out_of_range = oor_reg;
    assign is_last = last_reg;

    logic        ov_valid_reg, ov_valid_next;
    assign out_valid = ov_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            cnt_reg <= '0;
            blocks_reg <= '0;
            boff_reg <= '0;
            bsum_reg <= '0;
            blen_reg <= '0;
            xor_reg <= '0;
            held_reg <= '0;
            flags_reg <= '0;
            foff_reg <= '0;
            clr_reg <= '0;
            cp_reg <= '0;
            rd_reg <= '0;
            ov_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg <= cnt_next;
            blocks_reg <= blocks_next;
            boff_reg <= boff_next;
            bsum_reg <= bsum_next;
            blen_reg <= blen_next;
            xor_reg <= xor_next;
            held_reg <= held_next;
            flags_reg <= flags_next;
            foff_reg <= foff_next;
            clr_reg <= clr_next;
            cp_reg <= cp_next;
            rd_reg <= rd_next;
            ov_valid_reg <= ov_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg <= hi_next;
        okr_reg <= okr_next;
        kind_reg <= kind_next;
        last_reg <= last_next;
        word_reg <= word_next;
        oor_reg <= oor_next;
    end

    logic        too_long, xok, boor;
    logic [32:0] bend;
    logic [15:0] blocks_dec;
    logic [32:0] cp_addr;
    logic [32:0] a1;
    logic [15:0] xor_new;

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next = cnt_reg;
        blocks_next = blocks_reg;
        boff_next = boff_reg;
        bsum_next = bsum_reg;
        blen_next = blen_reg;
        xor_next = xor_reg;
        held_next = held_reg;
        flags_next = flags_reg;
        foff_next = foff_reg;
        clr_next = clr_reg;
        cp_next = cp_reg;
        rd_next = rd_reg;
        hi_next = hi_reg;
        okr_next = okr_reg;
        kind_next = kind_reg;
        last_next = last_reg;
        word_next = word_reg;
        oor_next = oor_reg;
        ov_valid_next = ov_valid_reg && out_stall;
        pb_we = 1'b0;
        pb_waddr = cnt_reg[BLK_AW-1:0];
        pb_raddr = cp_reg[BLK_AW-1:0];
        sreq = '0;
        too_long = blen_reg > 16'(BLOCK_DEPTH);
        bend = {1'b0, boff_reg} + {17'b0, blen_reg};
        boor = too_long || (bend > 33'(DATA_DEPTH));
        blocks_dec = blocks_reg - 16'd1;
        cp_addr = {1'b0, boff_reg} + {16'b0, cp_reg} - 33'd1;
        a1 = {1'b0, foff_reg} + 33'd1;
        xor_new = xor_reg;
        xok = 1'b0;

        unique case (phase_reg)
            PH_HEADER:
            begin
                if (take)
                begin
                    if (cnt_reg == 16'd12)
                        blocks_next = {in_byte, 8'h00};
                    else if (cnt_reg == 16'd13)
                        blocks_next = {blocks_reg[15:8], in_byte};
                    cnt_next = cnt_reg + 16'd1;
                    if (cnt_reg == 16'd0)
                    begin
                        phase_next = PH_CLEAR;
                        clr_next = '0;
                    end
                    else if (cnt_reg == 16'd15)
                    begin
                        cnt_next = '0;
                        phase_next = (blocks_reg == 16'd0) ? PH_FLAGLEN : PH_BLKHDR;
                    end
                end
            end
            PH_CLEAR:
            begin
                sreq.we = 1'b1;
                sreq.waddr = clr_reg[DATA_AW-1:0];
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (DATA_AW+1)'(DATA_DEPTH - 1))
                    phase_next = PH_HEADER;
            end
            PH_BLKHDR:
            begin
                if (take)
                begin
                    if (cnt_reg < 16'd4)
                        boff_next = {boff_reg[23:0], in_byte};
                    else if (cnt_reg < 16'd6)
                        bsum_next = {bsum_reg[7:0], in_byte};
                    else
                        blen_next = {blen_reg[7:0], in_byte};
                    cnt_next = cnt_reg + 16'd1;
                    if (cnt_reg == 16'd7)
                    begin
                        cnt_next = '0;
                        xor_next = '0;
                        held_next = '0;
                        if (blen_next == 16'd0)
                        begin
                            blocks_next = blocks_dec;
                            ov_valid_next = 1'b1;
                            kind_next = 1'b0;
                            okr_next = (bsum_reg == 16'd0);
                            word_next = '0;
                            oor_next = (boff_reg > 32'(DATA_DEPTH));
                            last_next = (blocks_dec == 16'd0);
                            phase_next = (blocks_dec == 16'd0) ? PH_FLAGLEN : PH_BLKHDR;
                        end
                        else
                            phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                if (take)
                begin
                    pb_we = (cnt_reg < 16'(BLOCK_DEPTH));
                    if (!cnt_reg[0])
                    begin
                        held_next = in_byte;
                        if (cnt_reg + 16'd1 == blen_reg)
                            xor_new = xor_reg ^ {8'h00, in_byte};
                    end
                    else
                        xor_new = xor_reg ^ {held_reg, in_byte};
                    xor_next = xor_new;
                    cnt_next = cnt_reg + 16'd1;
                    if (cnt_next >= blen_reg)
                    begin
                        xok = !too_long && (xor_new == bsum_reg);
                        cnt_next = '0;
                        blocks_next = blocks_dec;
                        kind_next = 1'b0;
                        okr_next = xok;
                        word_next = '0;
                        oor_next = boor;
                        last_next = (blocks_dec == 16'd0);
                        if (xok)
                        begin
                            phase_next = PH_COPY;
                            cp_next = '0;
                        end
                        else
                        begin
                            ov_valid_next = 1'b1;
                            phase_next = (blocks_dec == 16'd0) ? PH_FLAGLEN : PH_BLKHDR;
                        end
                    end
                end
            end
            PH_COPY:
            begin
                // read k at step k, write k-1 with data from last read
                pb_raddr = cp_reg[BLK_AW-1:0];
                cp_next = cp_reg + 17'd1;
                if (cp_reg != 17'd0)
                begin
                    sreq.we = (cp_addr < 33'(DATA_DEPTH));
                    sreq.waddr = cp_addr[DATA_AW-1:0];
                    sreq.wdata = pb_rdata;
                end
                if (cp_reg == {1'b0, blen_reg})
                begin
                    ov_valid_next = 1'b1;
                    phase_next = (blocks_reg == 16'd0) ? PH_FLAGLEN : PH_BLKHDR;
                end
            end
            PH_FLAGLEN:
            begin
                if (take)
                begin
                    flags_next = {flags_reg[7:0], in_byte};
                    cnt_next = cnt_reg + 16'd1;
                    if (cnt_reg == 16'd1)
                    begin
                        cnt_next = '0;
                        phase_next = (flags_next == 16'd0) ? PH_HEADER : PH_FLAGOFF;
                    end
                end
            end
            PH_FLAGOFF:
            begin
                if (take)
                begin
                    foff_next = {foff_reg[23:0], in_byte};
                    cnt_next = cnt_reg + 16'd1;
                    if (cnt_reg == 16'd3)
                    begin
                        cnt_next = '0;
                        rd_next = '0;
                        phase_next = PH_FLAGRD;
                    end
                end
            end
            PH_FLAGRD:
            begin
                rd_next = rd_reg + 2'd1;
                unique case (rd_reg)
                    2'd0:
                        sreq.raddr = foff_reg[DATA_AW-1:0];
                    2'd1:
                    begin
                        sreq.raddr = a1[DATA_AW-1:0];
                        hi_next = (foff_reg < 32'(DATA_DEPTH)) ? ds_rdata : 8'h00;
                    end
                    default:
                    begin
                        flags_next = flags_reg - 16'd1;
                        ov_valid_next = 1'b1;
                        kind_next = 1'b1;
                        okr_next = 1'b0;
                        word_next = {hi_reg,
                                     (a1 < 33'(DATA_DEPTH)) ? ds_rdata : 8'h00};
                        oor_next = !(a1 < 33'(DATA_DEPTH));
                        last_next = (flags_next == 16'd0);
                        phase_next = (flags_next == 16'd0) ? PH_HEADER : PH_FLAGOFF;
                    end
                endcase
            end
            default:
            begin
                phase_next = PH_HEADER;
                cnt_next = '0;
            end
        endcase
    end
endmodule

// ===== design/bilx_checker.sv =====
module bilx_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        kind,
    input logic        block_ok,
    input logic [15:0] word_value
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(word_value))
        else $error("result dropped under stall");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("byte taken while result pending");
    a_verd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !kind |-> word_value == 16'd0)
        else $error("verdict carries a word");
    a_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind |-> !block_ok)
        else $error("flag word carries ok");
endmodule

bind block_image_loader_xor_check bilx_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
    .block_ok(block_ok), .word_value(word_value)
);

// ===== dv/tb_block_image_loader_xor_check.sv =====
module tb_block_image_loader_xor_check;
    import bilx_pkg::*;

    localparam int WATCHDOG_LIMIT = 300000;
    localparam int N_CONT = 9;
    localparam int N_DIR = 22;

    typedef struct {
        bit        kind;
        bit        ok;
        bit [15:0] word;
        bit        oor;
        bit        last;
    } beat_t;

    typedef struct {
        bit [7:0] b;
        bit       typed;
        beat_t    exp;
        int       mode;
    } stim_t;

    typedef struct {
        bit [31:0] v;
        int        n;
        bit        typed;
        beat_t     exp;
    } row_t;

    localparam beat_t NO_BEAT = '{1'b0, 1'b0, 16'h0000, 1'b0, 1'b0};

    // header with three blocks: empty, overflowing the store, one byte; then flags
    row_t dir_tab [N_DIR] = '{
        '{32'h0, 4, 1'b0, NO_BEAT},
        '{32'h0, 4, 1'b0, NO_BEAT},
        '{32'h0, 4, 1'b0, NO_BEAT},
        '{32'h3, 2, 1'b0, NO_BEAT},
        '{32'h0, 2, 1'b0, NO_BEAT},
        '{32'h0, 4, 1'b0, NO_BEAT},
        '{32'h0, 2, 1'b0, NO_BEAT},
        '{32'h0, 2, 1'b1, '{1'b0, 1'b1, 16'h0000, 1'b0, 1'b0}},
        '{32'h0000FFFF, 4, 1'b0, NO_BEAT},
        '{32'h1262, 2, 1'b0, NO_BEAT},
        '{32'h3, 2, 1'b0, NO_BEAT},
        '{32'h12, 1, 1'b0, NO_BEAT},
        '{32'h34, 1, 1'b0, NO_BEAT},
        '{32'h56, 1, 1'b1, '{1'b0, 1'b1, 16'h0000, 1'b1, 1'b0}},
        '{32'h0, 4, 1'b0, NO_BEAT},
        '{32'h00FF, 2, 1'b0, NO_BEAT},
        '{32'h1, 2, 1'b0, NO_BEAT},
        '{32'hFF, 1, 1'b1, '{1'b0, 1'b1, 16'h0000, 1'b0, 1'b1}},
        '{32'h3, 2, 1'b0, NO_BEAT},
        '{32'h0000FFFF, 4, 1'b1, '{1'b1, 1'b0, 16'h1200, 1'b1, 1'b0}},
        '{32'h0, 4, 1'b1, '{1'b1, 1'b0, 16'hFF00, 1'b0, 1'b0}},
        '{32'hFFFFFFFF, 4, 1'b1, '{1'b1, 1'b0, 16'h0000, 1'b1, 1'b1}}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        kind;
    logic        block_ok;
    logic [15:0] word_value;
    logic        out_of_range;
    logic        is_last;

    block_image_loader_xor_check u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
        .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .block_ok(block_ok), .word_value(word_value),
        .out_of_range(out_of_range), .is_last(is_last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    stim_t stim_q[$];
    beat_t verdict_q[$];
    int    pos = 0;
    int    errors = 0;
    int    idle_cycles = 0;
    int    n_verdicts = 0;
    int    n_flags = 0;
    int    cur_mode = 0;

    // predictor state
    phase_t   ph;
    int       fcnt;
    bit [15:0] blk_left;
    bit [31:0] blk_off;
    bit [15:0] blk_sum;
    bit [15:0] blk_len;
    bit [15:0] xor_acc;
    bit [7:0]  held;
    bit [15:0] flg_left;
    bit [31:0] flg_off;
    bit [7:0]  pbuf [0:BLOCK_DEPTH-1];
    bit [7:0]  store [0:DATA_DEPTH-1];

    function automatic int sender_idle(int m);
        return (m == 0) ? 32 : (m == 1) ? 66 : 0;
    endfunction

    function automatic int recv_idle(int m);
        return (m == 0) ? 66 : (m == 1) ? 32 : 0;
    endfunction

    task automatic close_block(output beat_t r);
        bit too_long;
        bit ok;
        longint a;
        too_long = blk_len > BLOCK_DEPTH;
        ok = !too_long && (xor_acc == blk_sum);
        r.oor = too_long || (longint'(blk_off) + blk_len > DATA_DEPTH);
        if (ok)
        begin
            for (int k = 0; k < blk_len; k++)
            begin
                a = longint'(blk_off) + k;
                if (a < DATA_DEPTH)
                    store[a] = pbuf[k];
            end
        end
        blk_left = blk_left - 16'd1;
        r.kind = 1'b0;
        r.ok = ok;
        r.word = 16'h0;
        r.last = (blk_left == 0);
        fcnt = 0;
        ph = (blk_left == 0) ? PH_FLAGLEN : PH_BLKHDR;
    endtask

    task automatic predict_byte(input bit [7:0] b, output bit has, output beat_t r);
        longint a0;
        longint a1;
        has = 0;
        r = '{default: 0};
        case (ph)
            PH_HEADER:
            begin
                if (fcnt == 0)
                    foreach (store[i]) store[i] = 8'h00;
                if (fcnt == 12)
                    blk_left = {b, 8'h00};
                else if (fcnt == 13)
                    blk_left[7:0] = b;
                fcnt++;
                if (fcnt == 16)
                begin
                    fcnt = 0;
                    ph = (blk_left == 0) ? PH_FLAGLEN : PH_BLKHDR;
                end
            end
            PH_BLKHDR:
            begin
                if (fcnt < 4)
                    blk_off = {blk_off[23:0], b};
                else if (fcnt < 6)
                    blk_sum = {blk_sum[7:0], b};
                else
                    blk_len = {blk_len[7:0], b};
                fcnt++;
                if (fcnt == 8)
                begin
                    fcnt = 0;
                    xor_acc = 16'h0;
                    held = 8'h0;
                    if (blk_len == 0)
                    begin
                        close_block(r);
                        has = 1;
                    end
                    else
                        ph = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                if (fcnt < BLOCK_DEPTH)
                    pbuf[fcnt] = b;
                if ((fcnt & 1) == 0)
                begin
                    held = b;
                    if (fcnt + 1 == blk_len)
                        xor_acc ^= {8'h00, b};
                end
                else
                    xor_acc ^= {held, b};
                fcnt++;
                if (fcnt >= blk_len)
                begin
                    close_block(r);
                    has = 1;
                end
            end
            PH_FLAGLEN:
            begin
                flg_left = {flg_left[7:0], b};
                fcnt++;
                if (fcnt == 2)
                begin
                    fcnt = 0;
                    ph = (flg_left == 0) ? PH_HEADER : PH_FLAGOFF;
                end
            end
            default:
            begin
                flg_off = {flg_off[23:0], b};
                fcnt++;
                if (fcnt == 4)
                begin
                    fcnt = 0;
                    a0 = longint'(flg_off);
                    a1 = a0 + 1;
                    r.kind = 1'b1;
                    if (a0 < DATA_DEPTH) r.word[15:8] = store[a0]; else r.oor = 1;
                    if (a1 < DATA_DEPTH) r.word[7:0] = store[a1]; else r.oor = 1;
                    flg_left = flg_left - 16'd1;
                    r.last = (flg_left == 0);
                    if (flg_left == 0)
                        ph = PH_HEADER;
                    has = 1;
                end
            end
        endcase
    endtask

    // stimulus building
    task automatic push_be(input bit [31:0] v, input int n);
        stim_t s;
        for (int i = n - 1; i >= 0; i--)
        begin
            s = '{default: 0};
            s.b = v[8*i +: 8];
            s.mode = cur_mode;
            stim_q.insert(stim_q.size(), s);
        end
    endtask

    task automatic mark(input beat_t e);
        stim_q[stim_q.size()-1].typed = 1;
        stim_q[stim_q.size()-1].exp = e;
    endtask

    task automatic push_header(input bit [15:0] count);
        for (int i = 0; i < 12; i++)
            push_be($urandom_range(0, 255), 1);
        push_be({16'h0, count}, 2);
        push_be($urandom_range(0, 65535), 2);
    endtask

    task automatic push_block(input bit [31:0] off, input int len, input bit good);
        bit [7:0]  pl[$];
        bit [15:0] x;
        x = 16'h0;
        for (int i = 0; i < len; i++)
            pl.insert(pl.size(), 8'($urandom_range(0, 255)));
        for (int i = 0; i < len; i += 2)
            x ^= (i + 1 < len) ? {pl[i], pl[i+1]} : {8'h00, pl[i]};
        if (!good)
            x ^= 16'($urandom_range(1, 65535));
        push_be(off, 4);
        push_be({16'h0, x}, 2);
        push_be(len, 2);
        foreach (pl[i])
            push_be({24'h0, pl[i]}, 1);
    endtask

    task automatic push_container(input int k);
        int nb;
        int nf;
        int sel;
        bit [31:0] off;
        int len;
        nb = (k == 1) ? 0 : $urandom_range(1, 4);
        push_header(16'(nb));
        for (int i = 0; i < nb; i++)
        begin
            sel = $urandom_range(0, 99);
            off = (sel < 70) ? $urandom_range(0, 300) :
                  (sel < 85) ? $urandom_range(65500, 65535) : $urandom();
            sel = $urandom_range(0, 99);
            len = (sel < 85) ? $urandom_range(1, 24) :
                  (sel < 95) ? 0 : $urandom_range(40, 64);
            push_block(off, len, $urandom_range(0, 99) < 80);
        end
        nf = (k == 2) ? 0 : $urandom_range(1, 12);
        push_be(nf, 2);
        for (int i = 0; i < nf; i++)
        begin
            sel = $urandom_range(0, 99);
            off = (sel < 70) ? $urandom_range(0, 320) :
                  (sel < 85) ? $urandom_range(65530, 65535) : $urandom();
            push_be(off, 4);
        end
    endtask

    task automatic report(input string what, input int got, input int want);
        errors++;
        $display("MISMATCH %s: got %0h, want %0h (verdicts %0d, flags %0d)",
                 what, got, want, n_verdicts, n_flags);
    endtask

    // input driver
    always @(posedge clk)
    begin
        bit    has;
        beat_t r;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_byte(stim_q[pos].b, has, r);
                if (has)
                    verdict_q.insert(verdict_q.size(),
                                     stim_q[pos].typed ? stim_q[pos].exp : r);
                pos++;
            end
            if (in_valid && in_stall)
                ;
            else if (pos < stim_q.size() &&
                     $urandom_range(0, 99) >= sender_idle(stim_q[pos].mode))
            begin
                in_valid <= 1'b1;
                in_byte <= stim_q[pos].b;
            end
            else
                in_valid <= 1'b0;
            out_stall <= $urandom_range(0, 99) <
                recv_idle(stim_q[(pos < stim_q.size()) ? pos : stim_q.size()-1].mode);
        end
    end

    // result checker and watchdog
    always @(posedge clk)
    begin
        beat_t e;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (verdict_q.size() == 0)
                    report("unexpected beat kind", kind, 0);
                else
                begin
                    e = verdict_q.pop_front();
                    if (e.kind) n_flags++; else n_verdicts++;
                    if (kind !== e.kind) report("kind", kind, e.kind);
                    if (block_ok !== e.ok) report("block_ok", block_ok, e.ok);
                    if (word_value !== e.word) report("word_value", word_value, e.word);
                    if (out_of_range !== e.oor) report("out_of_range", out_of_range, e.oor);
                    if (is_last !== e.last) report("is_last", is_last, e.last);
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog expired with %0d beats pending", verdict_q.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        ph = PH_HEADER;
        fcnt = 0;
        blk_left = 0;
        blk_off = 0;
        blk_sum = 0;
        blk_len = 0;
        xor_acc = 0;
        held = 0;
        flg_left = 0;
        flg_off = 0;
        foreach (pbuf[i]) pbuf[i] = 8'h00;
        foreach (store[i]) store[i] = 8'h00;

        cur_mode = 0;
        for (int i = 0; i < N_DIR; i++)
        begin
            push_be(dir_tab[i].v, dir_tab[i].n);
            if (dir_tab[i].typed)
                mark(dir_tab[i].exp);
        end

        for (int k = 0; k < N_CONT; k++)
        begin
            cur_mode = (k < 3) ? 0 : (k < 6) ? 1 : 2;
            push_container(k);
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pos < stim_q.size() || verdict_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("Fed %0d container bytes over %0d containers", stim_q.size(),
                 N_CONT + 1);
        $display("Checked %0d block verdicts and %0d flag words", n_verdicts, n_flags);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
